@@ hdl/smpq_pkg.sv @@
// Shared definitions for the sorted minimum priority queue.
// Holds operation and status codes and the per-cell command type.
// No dependencies.
`default_nettype none

package smpq_pkg;

  // Width of the symbol field, fixed by the interface.
  localparam int unsigned SYM_BITS = 8;

  // Operation codes on op_i.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // Status codes on status_o.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_ROTATE
  } cell_op_e;

endpackage

`default_nettype wire

@@ hdl/smpq_cell.sv @@
// One slot of the sorted chain: holds a single entry and its valid flag.
// Depends on smpq_pkg for the cell command type.
`default_nettype none

module smpq_cell #(
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned ENT_BITS  = 49
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire smpq_pkg::cell_op_e      op_i,
  input  wire logic [KEY_BITS-1:0]     key_i,
  input  wire logic [ENT_BITS-1:0]     new_ent_i,
  input  wire logic [ENT_BITS-1:0]     prev_ent_i,
  input  wire logic                    prev_vld_i,
  input  wire logic                    prev_place_i,
  input  wire logic [ENT_BITS-1:0]     next_ent_i,
  input  wire logic                    next_vld_i,
  input  wire logic [ENT_BITS-1:0]     head_ent_i,
  output logic [ENT_BITS-1:0]          ent_o,
  output logic                         vld_o,
  output logic                         place_o
);

  logic [ENT_BITS-1:0] ent_q, ent_d;
  logic                vld_q, vld_d;

  // A new key belongs at or before this slot when the slot is empty or
  // holds a strictly larger key, so equal keys keep arrival order.
  assign place_o = ~vld_q | (ent_q[ENT_BITS-1 -: KEY_BITS] > key_i);

  always_comb begin
    ent_d = ent_q;
    vld_d = vld_q;
    case (op_i)
      smpq_pkg::CELL_INSERT: begin
        if (place_o && !prev_place_i) begin
          ent_d = new_ent_i;
          vld_d = 1'b1;
        end else if (place_o) begin
          ent_d = prev_ent_i;
          vld_d = prev_vld_i;
        end
      end
      smpq_pkg::CELL_POP: begin
        ent_d = next_ent_i;
        vld_d = next_vld_i;
      end
      smpq_pkg::CELL_ROTATE: begin
        // The last occupied slot wraps around to the head entry.
        if (next_vld_i) begin
          ent_d = next_ent_i;
        end else if (vld_q) begin
          ent_d = head_ent_i;
        end
      end
      default: begin
        ent_d = ent_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;
  assign vld_o = vld_q;

endmodule

`default_nettype wire

@@ hdl/sorted_min_priority_queue_core.sv @@
// Top level of the sorted minimum priority queue: a chain of smpq_cell slots
// plus command decode, the search sequencer and the result register.
// Depends on smpq_pkg and smpq_cell.
//
//   Channel   Handshake          Payload
//   --------  -----------------  --------------------------------------------
//   command   start_i / busy_o   op_i, frequency_i, symbol_i, node_handle_i
//   result    done_o (strobe)    status_o, out_frequency_o, out_symbol_o,
//                                out_handle_o, count_o
//
// A command transfer happens on a rising edge with start_i high and busy_o low.
// Add and pop never raise busy_o: every cell updates from its neighbors at the
// transfer edge and the result is presented on the next cycle, while a new
// command may already transfer. A search rotates the stored entries once around
// the occupied part of the chain, one step per cycle, comparing the head cell;
// busy_o stays high until the rotation ends, and the result is presented in the
// same cycle that busy_o falls. A search of an empty queue never raises busy_o
// and reports on the next cycle. The order of the queue is restored when the
// rotation ends.
// Reset clears all valid flags and the count; entry payloads are not reset.
// Each result is shown for exactly one cycle; the receiver cannot stall it.
`default_nettype none

module sorted_min_priority_queue_core #(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned HANDLE_BITS = 9
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [1:0]                       op_i,
  input  wire logic [KEY_BITS-1:0]              frequency_i,
  input  wire logic [smpq_pkg::SYM_BITS-1:0]    symbol_i,
  input  wire logic [HANDLE_BITS-1:0]           node_handle_i,
  output logic                                  done_o,
  output logic [1:0]                            status_o,
  output logic [KEY_BITS-1:0]                   out_frequency_o,
  output logic [smpq_pkg::SYM_BITS-1:0]         out_symbol_o,
  output logic [HANDLE_BITS-1:0]                out_handle_o,
  output logic [$clog2(DEPTH+1)-1:0]            count_o
);

  localparam int unsigned SYM_BITS = smpq_pkg::SYM_BITS;
  localparam int unsigned ENT_BITS = KEY_BITS + SYM_BITS + HANDLE_BITS;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);

  // Chain wiring. Entries are packed as {frequency, symbol, handle}.
  logic [ENT_BITS-1:0] cell_ent  [DEPTH];
  logic [DEPTH-1:0]    cell_vld;
  logic [DEPTH-1:0]    cell_place;
  logic [ENT_BITS-1:0] prev_ent  [DEPTH];
  logic [DEPTH-1:0]    prev_vld;
  logic [DEPTH-1:0]    prev_place;
  logic [ENT_BITS-1:0] next_ent  [DEPTH];
  logic [DEPTH-1:0]    next_vld;

  smpq_pkg::cell_op_e  cell_op;
  logic [ENT_BITS-1:0] new_ent;
  logic [ENT_BITS-1:0] head_ent;

  // Control and result registers.
  logic [CNT_W-1:0]    count_q, count_d;
  logic                search_q, search_d;
  logic [CNT_W-1:0]    remain_q, remain_d;
  logic [SYM_BITS-1:0] skey_q, skey_d;
  logic                found_q, found_d;
  logic [ENT_BITS-1:0] found_ent_q, found_ent_d;

  logic                done_q, done_d;
  logic [1:0]          status_q, status_d;
  logic [ENT_BITS-1:0] res_ent_q, res_ent_d;
  logic [CNT_W-1:0]    res_cnt_q, res_cnt_d;

  logic accept;
  logic full;
  logic head_hit;

  assign new_ent  = {frequency_i, symbol_i, node_handle_i};
  assign head_ent = cell_ent[0];
  assign accept   = start_i & ~busy_o;
  assign full     = (count_q == CNT_W'(DEPTH));
  assign head_hit = cell_vld[0] & (head_ent[HANDLE_BITS +: SYM_BITS] == skey_q);

  // The chain of cells. Each cell sees its two neighbors, the broadcast key and
  // the head entry used to close the ring during a search.
  for (genvar g = 0; g < DEPTH; g++) begin : g_chain
    if (g == 0) begin : g_first
      assign prev_ent[g]   = '0;
      assign prev_vld[g]   = 1'b0;
      assign prev_place[g] = 1'b0;
    end else begin : g_mid
      assign prev_ent[g]   = cell_ent[g-1];
      assign prev_vld[g]   = cell_vld[g-1];
      assign prev_place[g] = cell_place[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_ent[g] = '0;
      assign next_vld[g] = 1'b0;
    end else begin : g_inner
      assign next_ent[g] = cell_ent[g+1];
      assign next_vld[g] = cell_vld[g+1];
    end

    smpq_cell #(
      .KEY_BITS (KEY_BITS),
      .ENT_BITS (ENT_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (cell_op),
      .key_i        (frequency_i),
      .new_ent_i    (new_ent),
      .prev_ent_i   (prev_ent[g]),
      .prev_vld_i   (prev_vld[g]),
      .prev_place_i (prev_place[g]),
      .next_ent_i   (next_ent[g]),
      .next_vld_i   (next_vld[g]),
      .head_ent_i   (head_ent),
      .ent_o        (cell_ent[g]),
      .vld_o        (cell_vld[g]),
      .place_o      (cell_place[g])
    );
  end

  // Command decode and search sequencing.
  always_comb begin
    cell_op     = smpq_pkg::CELL_HOLD;
    count_d     = count_q;
    search_d    = search_q;
    remain_d    = remain_q;
    skey_d      = skey_q;
    found_d     = found_q;
    found_ent_d = found_ent_q;
    done_d      = 1'b0;
    status_d    = status_q;
    res_ent_d   = res_ent_q;
    res_cnt_d   = res_cnt_q;

    if (search_q) begin
      // Rotate one step and look at the entry currently at the head.
      cell_op  = smpq_pkg::CELL_ROTATE;
      remain_d = remain_q - CNT_W'(1);
      if (head_hit && !found_q) begin
        found_d     = 1'b1;
        found_ent_d = head_ent;
      end
      if (remain_q == CNT_W'(1)) begin
        search_d  = 1'b0;
        done_d    = 1'b1;
        res_cnt_d = count_q;
        if (found_q) begin
          status_d  = smpq_pkg::ST_OK;
          res_ent_d = found_ent_q;
        end else if (head_hit) begin
          status_d  = smpq_pkg::ST_OK;
          res_ent_d = head_ent;
        end else begin
          status_d  = smpq_pkg::ST_NOT_FOUND;
          res_ent_d = '0;
        end
      end
    end else if (accept) begin
      res_ent_d = '0;
      status_d  = smpq_pkg::ST_OK;
      unique case (op_i)
        smpq_pkg::OP_ADD: begin
          done_d = 1'b1;
          if (full) begin
            status_d = smpq_pkg::ST_FULL;
          end else begin
            cell_op = smpq_pkg::CELL_INSERT;
            count_d = count_q + CNT_W'(1);
          end
        end
        smpq_pkg::OP_POP: begin
          done_d = 1'b1;
          if (count_q == '0) begin
            status_d = smpq_pkg::ST_EMPTY;
          end else begin
            cell_op   = smpq_pkg::CELL_POP;
            count_d   = count_q - CNT_W'(1);
            res_ent_d = head_ent;
          end
        end
        smpq_pkg::OP_SEARCH: begin
          if (count_q == '0) begin
            done_d   = 1'b1;
            status_d = smpq_pkg::ST_NOT_FOUND;
          end else begin
            search_d = 1'b1;
            remain_d = count_q;
            skey_d   = symbol_i;
            found_d  = 1'b0;
          end
        end
        smpq_pkg::OP_NOP: begin
          done_d = 1'b1;
        end
        default: begin
          done_d = 1'b1;
        end
      endcase
      res_cnt_d = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      search_q <= 1'b0;
      remain_q <= '0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      count_q  <= count_d;
      search_q <= search_d;
      remain_q <= remain_d;
      found_q  <= found_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    skey_q      <= skey_d;
    found_ent_q <= found_ent_d;
    status_q    <= status_d;
    res_ent_q   <= res_ent_d;
    res_cnt_q   <= res_cnt_d;
  end

  assign busy_o          = search_q;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign out_frequency_o = res_ent_q[ENT_BITS-1 -: KEY_BITS];
  assign out_symbol_o    = res_ent_q[HANDLE_BITS +: SYM_BITS];
  assign out_handle_o    = res_ent_q[HANDLE_BITS-1:0];
  assign count_o         = res_cnt_q;

`ifndef ASSERT_OFF
  // The occupied cells always match the entry count.
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_vld) == 32'(count_q))
    else $error("cell valid flags disagree with the entry count");

  // The count never exceeds the depth of the chain.
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  // A result is never presented while a search is still rotating.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe during a search");

  // Add, pop and no-op transfers produce a result on the next cycle.
  a_fast_ops_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i != smpq_pkg::OP_SEARCH) |=> done_o)
    else $error("missing result after a single-cycle command");

  // A search rotation leaves the entry count untouched.
  a_search_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> $stable(count_q))
    else $error("entry count changed during a search");
`endif

endmodule

`default_nettype wire
